// ----- hdl/assert_macros.svh -----
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst, pre, post) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("check failed");
`endif

// ----- hdl/swrr_pkg.sv -----
// Package with types and constants of the weighted round-robin selector.
package swrr_pkg;
  localparam int SERVERS_DEF = 16;
  localparam int WEIGHT_BITS_DEF = 8;
  localparam logic [1:0] KIND_LOAD = 2'd0;
  localparam logic [1:0] KIND_SELECT = 2'd1;
  localparam logic [1:0] KIND_OK = 2'd2;
  localparam logic [1:0] KIND_FAIL = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  server;
    logic [31:0] now_seconds;
    logic [7:0]  weight;
    logic [7:0]  fail_limit;
    logic [15:0] fail_window;
    logic        fallback;
  } swrr_in_t;

  typedef struct packed {
    logic [3:0] chosen_server;
    logic       found;
    logic       server_down;
    logic [7:0] eff_weight;
  } swrr_out_t;

  typedef struct packed {
    logic       start;
    logic [7:0] dividend;
    logic [7:0] divisor;
  } swrr_div_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] quotient;
  } swrr_div_rsp_t;
endpackage

// ----- hdl/swrr_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
module swrr_div (
  input  logic                   clk,
  input  logic                   rst,
  input  swrr_pkg::swrr_div_req_t req,
  output swrr_pkg::swrr_div_rsp_t rsp
);
  import swrr_pkg::*;
  logic [7:0] rem, quo, dsr;
  logic [3:0] cnt;
  logic       run;
  logic       fin;
  logic [8:0] trial;

  assign trial = {rem, quo[7]} - {1'b0, dsr};
  assign rsp.quotient = quo;
  assign rsp.done = fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      cnt <= '0;
      fin <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= 4'd8;
        rem <= '0;
        quo <= req.dividend;
        dsr <= req.divisor;
      end else if (run) begin
        if (!trial[8]) begin
          rem <= trial[7:0];
          quo <= {quo[6:0], 1'b1};
        end else begin
          rem <= {rem[6:0], quo[7]};
          quo <= {quo[6:0], 1'b0};
        end
        cnt <= cnt - 4'd1;
        if (cnt == 4'd1) begin
          run <= 1'b0;
          fin <= 1'b1;
        end
      end
    end
  end
endmodule

// ----- hdl/smooth_weighted_round_robin_health.sv -----
// Top level of the health-aware smooth weighted round-robin selector.
// One transaction is taken while busy is low. A load, a connect-ok or a
// non-select for a server outside the table goes straight to S_RPT; a
// connect-fail waits in S_DIV for the serial divider (one quotient bit a
// cycle; skipped when the failure limit is zero), then S_FAIL; a select
// makes two passes over the N servers in use, as a single adder/comparator
// visits each table entry once per pass. The result appears for one cycle with
// done high and cannot be stalled; the next transaction may start in that cycle.
module smooth_weighted_round_robin_health #(
  parameter int SERVERS = swrr_pkg::SERVERS_DEF,
  parameter int WEIGHT_BITS = swrr_pkg::WEIGHT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  swrr_pkg::swrr_in_t  cmd,
  output logic                done,
  output swrr_pkg::swrr_out_t result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [4:0]          cfg_data
);
  import swrr_pkg::*;
  localparam int IW = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam int CW = IW + 1;
  localparam logic [7:0] WMASK = 8'((32'd1 << WEIGHT_BITS) - 32'd1);
  localparam logic [2:0] S_IDLE = 3'd0, S_P1 = 3'd1, S_P2 = 3'd2, S_FIN = 3'd3,
                         S_DIV = 3'd4, S_FAIL = 3'd5, S_RPT = 3'd6;

  logic [7:0]  base_w [SERVERS];
  logic [7:0]  eff_w [SERVERS];
  logic signed [15:0] cur_w [SERVERS];
  logic [7:0]  fcnt [SERVERS];
  logic [31:0] lft [SERVERS];
  logic        down [SERVERS];
  logic        fb [SERVERS];
  logic [7:0]  flim [SERVERS];
  logic [15:0] tmo [SERVERS];

  logic [2:0]  state;
  logic [4:0]  server_count;
  swrr_in_t    req;
  logic [IW-1:0] idx, best, sel;
  logic [CW-1:0] last;
  logic        fnd;
  logic signed [15:0] mx;
  logic [19:0] total;
  swrr_div_req_t dreq;
  swrr_div_rsp_t drsp;

  swrr_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  logic [31:0] dt;
  logic        skip, revive, in_tab, cmd_in_tab;
  logic [IW-1:0] cmd_idx;
  logic [7:0]  ew_i;
  logic signed [17:0] sum;
  logic signed [15:0] sat;
  logic [CW-1:0] ncount;

  assign cmd_idx = IW'(cmd.server);
  assign cmd_in_tab = (32'(cmd.server) < 32'(SERVERS));
  assign dt = req.now_seconds - lft[idx];
  assign skip = down[idx] && fb[idx] && (dt < {16'd0, tmo[idx]});
  assign revive = (dt > {16'd0, tmo[idx]}) && down[idx] && (eff_w[idx] == 8'd0);
  assign ew_i = revive ? 8'd1 : eff_w[idx];
  assign in_tab = (32'(req.server) < 32'(SERVERS));
  assign sum = (state == S_FIN) ? 18'(cur_w[best]) - 18'(signed'({1'b0, total[16:0]}))
                                : 18'(cur_w[idx]) + 18'(signed'({1'b0, ew_i}));
  assign sat = (sum > 18'sd32767) ? 16'sh7fff :
               (sum < -18'sd32768) ? 16'sh8000 : sum[15:0];
  always_comb begin
    if (server_count == 5'd0) ncount = CW'(1);
    else if (32'(server_count) > SERVERS) ncount = CW'(SERVERS);
    else ncount = CW'(server_count);
  end
  assign busy = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign dreq.start = (state == S_IDLE) && start && (cmd.kind == KIND_FAIL);
  assign dreq.dividend = base_w[cmd_idx];
  assign dreq.divisor = flim[cmd_idx];

  logic [31:0] dtf;
  logic [7:0]  cnt_next, ew_next;
  logic        fail_down;
  assign dtf = req.now_seconds - lft[sel];

  always_comb begin
    ew_next = eff_w[sel];
    if (flim[sel] != 8'd0)
      ew_next = (eff_w[sel] > drsp.quotient) ? eff_w[sel] - drsp.quotient : 8'd0;
    cnt_next = fcnt[sel];
    if (dtf > {16'd0, tmo[sel]}) cnt_next = 8'd1;
    else if (cnt_next != 8'd255) cnt_next = cnt_next + 8'd1;
    fail_down = (cnt_next != 8'd0) && (cnt_next >= flim[sel]);
    if (fail_down) ew_next = 8'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      server_count <= 5'd1;
      done <= 1'b0;
      for (int i = 0; i < SERVERS; i++) begin
        base_w[i] <= '0; eff_w[i] <= '0; cur_w[i] <= '0; fcnt[i] <= '0;
        lft[i] <= '0; down[i] <= 1'b0; fb[i] <= 1'b0; flim[i] <= '0; tmo[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      if (cfg_valid) server_count <= cfg_data;
      unique case (state)
        S_IDLE: if (start) begin
          req <= cmd;
          sel <= cmd_idx;
          idx <= '0;
          last <= ncount - CW'(1);
          total <= '0;
          mx <= '0;
          fnd <= 1'b0;
          best <= '0;
          if (cmd.kind == KIND_SELECT) state <= S_P1;
          else if (!cmd_in_tab) state <= S_RPT;
          else if (cmd.kind == KIND_FAIL) state <= S_DIV;
          else state <= S_RPT;
          if (cmd.kind == KIND_LOAD && cmd_in_tab) begin
            base_w[cmd_idx] <= cmd.weight & WMASK;
            flim[cmd_idx] <= cmd.fail_limit;
            tmo[cmd_idx] <= cmd.fail_window;
            fb[cmd_idx] <= cmd.fallback;
            eff_w[cmd_idx] <= cmd.weight & WMASK;
            cur_w[cmd_idx] <= '0;
            fcnt[cmd_idx] <= '0;
            lft[cmd_idx] <= '0;
            down[cmd_idx] <= 1'b0;
          end
          if (cmd.kind == KIND_OK && cmd_in_tab) begin
            if (down[cmd_idx]) begin
              down[cmd_idx] <= 1'b0;
              fcnt[cmd_idx] <= '0;
            end
            if (eff_w[cmd_idx] < base_w[cmd_idx])
              eff_w[cmd_idx] <= eff_w[cmd_idx] + 8'd1;
          end
        end
        S_P1: begin
          if (!skip) begin
            eff_w[idx] <= ew_i;
            total <= total + 20'(ew_i);
            cur_w[idx] <= sat;
          end
          if (CW'(idx) == last) begin
            idx <= '0;
            state <= S_P2;
          end else idx <= idx + IW'(1);
        end
        S_P2: begin
          if (!skip && cur_w[idx] > mx) begin
            mx <= cur_w[idx];
            best <= idx;
            fnd <= 1'b1;
          end
          if (CW'(idx) == last) state <= S_FIN;
          else idx <= idx + IW'(1);
        end
        S_FIN: begin
          if (fnd) cur_w[best] <= sat;
          sel <= best;
          state <= S_RPT;
        end
        S_DIV: if (drsp.done || flim[sel] == 8'd0) state <= S_FAIL;
        S_FAIL: begin
          if (fail_down || dtf > {16'd0, tmo[sel]}) lft[sel] <= req.now_seconds;
          if (fail_down) down[sel] <= 1'b1;
          fcnt[sel] <= cnt_next;
          eff_w[sel] <= ew_next;
          state <= S_RPT;
        end
        S_RPT: begin
          done <= 1'b1;
          state <= S_IDLE;
          if (req.kind == KIND_SELECT) begin
            result.chosen_server <= 4'(best);
            result.found <= fnd;
            result.server_down <= down[best];
            result.eff_weight <= eff_w[best];
          end else begin
            result.chosen_server <= '0;
            result.found <= 1'b0;
            result.server_down <= in_tab ? down[sel] : 1'b0;
            result.eff_weight <= in_tab ? eff_w[sel] : 8'd0;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- hdl/swrr_checker.sv -----
// Port-level checker for the selector, bound to the top level.
`include "assert_macros.svh"
module swrr_checker (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input swrr_pkg::swrr_out_t result
);
  import swrr_pkg::*;
  `CHK_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `CHK_IMPLY(a_done_idle, clk, rst, done, !busy)
  `CHK_NEXT(a_done_single, clk, rst, done, !done)
  `CHK_IMPLY(a_found_zero, clk, rst, done && !result.found, result.chosen_server == 4'd0)
endmodule

bind smooth_weighted_round_robin_health swrr_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done), .result(result)
);

// ----- sim/testbench.sv -----
// Testbench for the health-aware smooth weighted round-robin selector.
`timescale 1ns / 1ps

module testbench;
  import swrr_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  swrr_in_t cmd = '0;
  logic done;
  swrr_out_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [4:0] cfg_data = 5'd1;

  smooth_weighted_round_robin_health uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .done(done),
    .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  localparam int NSRV = 16;

  logic [7:0] base_w[NSRV];
  logic [7:0] eff_w[NSRV];
  int cur_w[NSRV];
  logic [7:0] fails[NSRV];
  logic [31:0] fail_time[NSRV];
  logic down[NSRV];
  logic fb[NSRV];
  logic [7:0] limit[NSRV];
  logic [15:0] tmo[NSRV];
  logic [4:0] active_servers;

  swrr_out_t expected_q[$];
  int errors = 0;
  bit quiet = 1'b0;

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic bit is_skipped(logic [31:0] now, int i);
    logic [31:0] d;
    d = now - fail_time[i];
    return down[i] && fb[i] && (d < {16'd0, tmo[i]});
  endfunction

  function automatic swrr_out_t predict_pick(swrr_in_t c);
    swrr_out_t r;
    int n, best, total, top;
    bit hit;
    logic [31:0] d;
    logic [7:0] drop;
    int s;
    r = '0;
    s = int'(c.server);
    if (c.kind == KIND_SELECT) begin
      n = int'(active_servers);
      if (n == 0) n = 1;
      if (n > NSRV) n = NSRV;
      best = 0; total = 0; top = 0; hit = 1'b0;
      for (int i = 0; i < n; i++) begin
        if (!is_skipped(c.now_seconds, i)) begin
          d = c.now_seconds - fail_time[i];
          if (d > {16'd0, tmo[i]} && down[i] && eff_w[i] == 8'd0) eff_w[i] = 8'd1;
          total += int'(eff_w[i]);
          cur_w[i] = clamp16(cur_w[i] + int'(eff_w[i]));
        end
      end
      for (int i = 0; i < n; i++) begin
        if (!is_skipped(c.now_seconds, i) && cur_w[i] > top) begin
          top = cur_w[i]; best = i; hit = 1'b1;
        end
      end
      if (hit) cur_w[best] = clamp16(cur_w[best] - total);
      r.chosen_server = 4'(best);
      r.found = hit;
      r.server_down = down[best];
      r.eff_weight = eff_w[best];
      return r;
    end
    case (c.kind)
      KIND_LOAD: begin
        base_w[s] = c.weight; limit[s] = c.fail_limit; tmo[s] = c.fail_window;
        fb[s] = c.fallback; eff_w[s] = c.weight; cur_w[s] = 0; fails[s] = 8'd0;
        fail_time[s] = 32'd0; down[s] = 1'b0;
      end
      KIND_OK: begin
        if (down[s]) begin
          down[s] = 1'b0; fails[s] = 8'd0;
        end
        if (eff_w[s] < base_w[s]) eff_w[s]++;
      end
      default: begin
        if (limit[s] != 8'd0) begin
          drop = base_w[s] / limit[s];
          eff_w[s] = (eff_w[s] > drop) ? eff_w[s] - drop : 8'd0;
        end
        d = c.now_seconds - fail_time[s];
        if (d > {16'd0, tmo[s]}) begin
          fail_time[s] = c.now_seconds; fails[s] = 8'd1;
        end else if (fails[s] != 8'd255) begin
          fails[s]++;
        end
        d = c.now_seconds - fail_time[s];
        if (fails[s] != 8'd0 && fails[s] >= limit[s] && d <= {16'd0, tmo[s]}) begin
          down[s] = 1'b1; eff_w[s] = 8'd0; fail_time[s] = c.now_seconds;
        end
      end
    endcase
    r.server_down = down[s];
    r.eff_weight = eff_w[s];
    return r;
  endfunction

  task automatic send_cmd(swrr_in_t c);
    if (!quiet) begin
      while ($urandom_range(99) < 24) begin
        start <= 1'b0;
        @(posedge clk);
      end
    end
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    expected_q.push_back(predict_pick(c));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_server_count(logic [4:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    active_servers = v;
  endtask

  function automatic swrr_in_t make_cmd(logic [1:0] k, logic [3:0] s, logic [31:0] now);
    swrr_in_t c;
    c = '0;
    c.kind = k; c.server = s; c.now_seconds = now;
    return c;
  endfunction

  function automatic swrr_in_t make_load(logic [3:0] s, logic [7:0] w, logic [7:0] mf,
                                         logic [15:0] t, logic f);
    swrr_in_t c;
    c = make_cmd(KIND_LOAD, s, $urandom);
    c.weight = w; c.fail_limit = mf; c.fail_window = t; c.fallback = f;
    return c;
  endfunction

  function automatic swrr_in_t random_cmd(int nsrv);
    swrr_in_t c;
    int p;
    c = '0;
    c.weight = 8'($urandom); c.fail_limit = 8'($urandom_range(4));
    if ($urandom_range(9) == 0) c.fail_limit = 8'($urandom);
    c.fail_window = 16'($urandom_range(20));
    if ($urandom_range(9) == 0) c.fail_window = 16'($urandom);
    c.fallback = 1'($urandom);
    c.server = 4'($urandom_range(nsrv - 1));
    if ($urandom_range(19) == 0) c.server = 4'($urandom);
    c.now_seconds = 32'd1000 + $urandom_range(40);
    if ($urandom_range(19) == 0) c.now_seconds = $urandom;
    p = $urandom_range(99);
    if (p < 12) c.kind = KIND_LOAD;
    else if (p < 55) c.kind = KIND_SELECT;
    else if (p < 75) c.kind = KIND_OK;
    else c.kind = KIND_FAIL;
    return c;
  endfunction

  task automatic test_directed();
    write_server_count(5'd4);
    send_cmd(make_cmd(KIND_SELECT, 4'd0, 32'd0));
    send_cmd(make_load(4'd0, 8'd255, 8'd255, 16'hFFFF, 1'b1));
    send_cmd(make_load(4'd1, 8'd5, 8'd2, 16'd10, 1'b1));
    send_cmd(make_load(4'd2, 8'd1, 8'd0, 16'd0, 1'b0));
    send_cmd(make_load(4'd3, 8'd0, 8'd1, 16'd3, 1'b1));
    send_cmd(make_cmd(KIND_SELECT, 4'd0, 32'd5));
    send_cmd(make_cmd(KIND_SELECT, 4'd0, 32'd6));
    send_cmd(make_cmd(KIND_FAIL, 4'd2, 32'd7));
    send_cmd(make_cmd(KIND_FAIL, 4'd1, 32'd20));
    send_cmd(make_cmd(KIND_FAIL, 4'd1, 32'd21));
    send_cmd(make_cmd(KIND_SELECT, 4'd0, 32'd22));
    send_cmd(make_cmd(KIND_SELECT, 4'd0, 32'd40));
    send_cmd(make_cmd(KIND_OK, 4'd1, 32'd41));
    send_cmd(make_cmd(KIND_OK, 4'd2, 32'd41));
    send_cmd(make_cmd(KIND_FAIL, 4'd3, 32'hFFFF_FFFF));
    send_cmd(make_cmd(KIND_SELECT, 4'd0, 32'd0));
    send_cmd(make_cmd(KIND_FAIL, 4'd15, 32'd1));
    send_cmd(make_cmd(KIND_OK, 4'd15, 32'd1));
    write_server_count(5'd0);
    send_cmd(make_cmd(KIND_SELECT, 4'd0, 32'd50));
    write_server_count(5'd31);
    send_cmd(make_load(4'd15, 8'd200, 8'd3, 16'd100, 1'b0));
    send_cmd(make_cmd(KIND_SELECT, 4'd0, 32'd60));
    send_cmd(make_cmd(KIND_SELECT, 4'd0, 32'd61));
  endtask

  task automatic test_random(int count, logic [4:0] nsrv, bit no_gaps);
    int span;
    write_server_count(nsrv);
    span = (nsrv == 5'd0) ? 1 : ((int'(nsrv) > NSRV) ? NSRV : int'(nsrv));
    quiet = no_gaps;
    for (int i = 0; i < count; i++) send_cmd(random_cmd(span));
    quiet = 1'b0;
  endtask

  always @(posedge clk) begin
    swrr_out_t want;
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        $error("result with no command outstanding");
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (result.chosen_server !== want.chosen_server) begin
          $error("chosen_server expected %0d actual %0d", want.chosen_server,
                 result.chosen_server);
          errors++;
        end
        if (result.found !== want.found) begin
          $error("found expected %0d actual %0d", want.found, result.found);
          errors++;
        end
        if (result.server_down !== want.server_down) begin
          $error("server_down expected %0d actual %0d", want.server_down,
                 result.server_down);
          errors++;
        end
        if (result.eff_weight !== want.eff_weight) begin
          $error("eff_weight expected %0d actual %0d", want.eff_weight, result.eff_weight);
          errors++;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < NSRV; i++) begin
      base_w[i] = '0; eff_w[i] = '0; cur_w[i] = 0; fails[i] = '0; fail_time[i] = '0;
      down[i] = 1'b0; fb[i] = 1'b0; limit[i] = '0; tmo[i] = '0;
    end
    active_servers = 5'd1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(150, 5'd16, 1'b0);
    test_random(100, 5'd3, 1'b1);
    test_random(150, 5'd1, 1'b0);
    test_random(200, 5'd8, 1'b0);
    drain_results();
    if (errors == 0) begin
      $display("smooth_weighted_round_robin_health test passed");
    end else begin
      $display("smooth_weighted_round_robin_health test failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("smooth_weighted_round_robin_health test failed");
    $finish;
  end
endmodule
